// ===== design/kabf_pkg.sv =====
// Shared constants and codes for the one-axis angle and gyro bias Kalman filter.
package kabf_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC          = 24;

  localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd503316;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    OP_ANGLE_PRED = 4'd0,
    OP_DP         = 4'd1,
    OP_C00_PRED   = 4'd2,
    OP_C11_PRED   = 4'd3,
    OP_ANGLE_CORR = 4'd4,
    OP_BIAS_CORR  = 4'd5,
    OP_C10_CORR   = 4'd6,
    OP_C00_CORR   = 4'd7,
    OP_C11_CORR   = 4'd8,
    OP_C01_CORR   = 4'd9
  } op_t;

endpackage

// ===== design/kabf_mul.sv =====
// Shared fixed-point multiplier: 16-bit digits per cycle, rounding and saturation.
module kabf_mul import kabf_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [((WORD_BITS > 32) ? WORD_BITS : 32):0] a,
  input  logic signed [((WORD_BITS > 32) ? WORD_BITS : 32):0] b,
  output logic                                done,
  output logic signed [WORD_BITS-1:0]         res
);

  localparam int MAG = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int OW  = MAG + 1;
  localparam int NCH = (MAG + 15) / 16;
  localparam int YW  = NCH * 16;
  localparam int PW  = MAG + YW;
  localparam int MW  = PW + 1 - FRAC;
  localparam int CW  = $clog2(NCH + 1);

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [MAG-1:0]       x;
  logic [YW-1:0]        yr;
  logic [PW-1:0]        acc;
  logic                 neg;
  logic signed [OW-1:0] an;
  logic signed [OW-1:0] bn;
  logic [MAG+15:0]      prod;
  logic [PW:0]          rsum;
  logic [MW-1:0]        m;
  logic [MW-1:0]        lim;
  logic signed [WORD_BITS-1:0] rval;

  always_comb begin
    an   = -a;
    bn   = -b;
    prod = (MAG+16)'(x) * (MAG+16)'(yr[YW-1 -: 16]);
    rsum = {1'b0, acc} + ((PW+1)'(1) << (FRAC - 1));
    m    = rsum[PW:FRAC];
    lim  = MW'(1) << (WORD_BITS - 1);
    if (neg) begin
      rval = (m > lim) ? WMIN : -(WORD_BITS'(m));
    end else begin
      rval = (m >= lim) ? WMAX : WORD_BITS'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(NCH);
        acc  <= '0;
        neg  <= a[OW-1] ^ b[OW-1];
        x    <= a[OW-1] ? an[MAG-1:0] : a[MAG-1:0];
        yr   <= YW'(b[OW-1] ? bn[MAG-1:0] : b[MAG-1:0]);
      end else if (busy) begin
        if (cnt != '0) begin
          acc <= (acc << 16) + PW'(prod);
          yr  <= yr << 16;
          cnt <= cnt - CW'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= rval;
        end
      end
    end
  end

endmodule

// ===== design/kabf_div.sv =====
// Restoring divider for the gains: one quotient bit per cycle, rounded and saturated.
module kabf_div import kabf_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [WORD_BITS-1:0]         num,
  input  logic [((WORD_BITS > 32) ? WORD_BITS : 32):0] den,
  output logic                                done,
  output logic signed [WORD_BITS-1:0]         res
);

  localparam int MAG = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int DW  = MAG + 1;
  localparam int NB  = WORD_BITS + FRAC;
  localparam int CW  = $clog2(NB + 1);

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DW-1:0]        d;
  logic [DW-1:0]        r;
  logic [NB-1:0]        dq;
  logic                 neg;
  logic signed [WORD_BITS-1:0] nn;
  logic [DW:0]          rsh;
  logic                 qbit;
  logic                 rnd;
  logic [NB:0]          q;
  logic [NB:0]          lim;
  logic signed [WORD_BITS-1:0] rval;

  always_comb begin
    nn   = -num;
    rsh  = {r, dq[NB-1]};
    qbit = (rsh >= {1'b0, d});
    rnd  = ({r, 1'b0} >= {1'b0, d});
    q    = {1'b0, dq} + (NB+1)'(rnd);
    lim  = (NB+1)'(1) << (WORD_BITS - 1);
    if (neg) begin
      rval = (q > lim) ? WMIN : -(WORD_BITS'(q));
    end else begin
      rval = (q >= lim) ? WMAX : WORD_BITS'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(NB);
        d    <= den;
        r    <= '0;
        neg  <= num[WORD_BITS-1];
        dq   <= {(num[WORD_BITS-1] ? nn : num), {FRAC{1'b0}}};
      end else if (busy) begin
        if (cnt != '0) begin
          r   <= qbit ? DW'(rsh - {1'b0, d}) : rsh[DW-1:0];
          dq  <= {dq[NB-2:0], qbit};
          cnt <= cnt - CW'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= rval;
        end
      end
    end
  end

endmodule

// ===== design/kalman_angle_bias_filter.sv =====
// One-axis Kalman filter tracking angle and gyro bias, with a shared multiplier and divider.
// Each transaction runs ten multiplies and two divides and then loads the result; a non-positive
// innovation variance skips both divides. A new transaction is taken only in the idle state.
// The gain divides take most of the time; a waiting result does not hold off the next
// transaction, but the next result stays in the output state until the waiting one is taken.
// Synchronous reset clears the filter state and returns the noise registers to defaults.
module kalman_angle_bias_filter import kabf_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // measured_angle [31:0], measured_rate [63:32], time_step [87:64]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // filtered_angle [31:0], gyro_bias [63:32], unbiased_rate [95:64]
  output logic [95:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAG = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int OW  = MAG + 1;
  localparam int XW  = MAG + 4;

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [31:0] OMAX = 32'sh7fffffff;
  localparam logic signed [31:0] OMIN = 32'sh80000000;

  function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [XW-1:0] v);
    if (v > XW'(WMAX)) begin
      return WMAX;
    end else if (v < XW'(WMIN)) begin
      return WMIN;
    end
    return WORD_BITS'(v);
  endfunction

  function automatic logic signed [31:0] sat_o(input logic signed [WORD_BITS-1:0] v);
    if (XW'(v) > XW'(OMAX)) begin
      return OMAX;
    end else if (XW'(v) < XW'(OMIN)) begin
      return OMIN;
    end
    return 32'(v);
  endfunction

  function automatic op_t op_after(input op_t o);
    case (o)
      OP_ANGLE_PRED: return OP_DP;
      OP_DP:         return OP_C00_PRED;
      OP_C00_PRED:   return OP_C11_PRED;
      OP_C11_PRED:   return OP_ANGLE_CORR;
      OP_ANGLE_CORR: return OP_BIAS_CORR;
      OP_BIAS_CORR:  return OP_C10_CORR;
      OP_C10_CORR:   return OP_C00_CORR;
      OP_C00_CORR:   return OP_C11_CORR;
      OP_C11_CORR:   return OP_C01_CORR;
      default:       return OP_ANGLE_PRED;
    endcase
  endfunction

  state_t state;
  op_t    op;
  logic   go;
  logic   divsel;

  logic [30:0] angle_noise;
  logic [30:0] bias_noise;
  logic [30:0] meas_noise;

  logic signed [31:0]          m_angle;
  logic [23:0]                 dt;
  logic signed [WORD_BITS-1:0] angle;
  logic signed [WORD_BITS-1:0] bias;
  logic signed [WORD_BITS-1:0] rate;
  logic signed [WORD_BITS-1:0] c00;
  logic signed [WORD_BITS-1:0] c01;
  logic signed [WORD_BITS-1:0] c10;
  logic signed [WORD_BITS-1:0] c11;
  logic signed [WORD_BITS-1:0] dp;
  logic signed [WORD_BITS-1:0] y;
  logic signed [WORD_BITS-1:0] k0;
  logic signed [WORD_BITS-1:0] k1;
  logic [95:0]                 out_data;

  logic signed [31:0]          in_rate;
  logic signed [OW-1:0]        opa;
  logic signed [OW-1:0]        opb;
  logic signed [WORD_BITS-1:0] pred_tmp;
  logic signed [XW-1:0]        s_sum;
  logic                        s_pos;
  logic                        mul_go;
  logic                        mul_done;
  logic signed [WORD_BITS-1:0] mul_res;
  logic                        div_go;
  logic                        div_done;
  logic signed [WORD_BITS-1:0] div_res;
  logic                        cfg_wr;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = out_data;
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_rate  = s_tdata[63:32];

  assign s_sum  = XW'(c00) + XW'($signed({1'b0, meas_noise}));
  assign s_pos  = (s_sum > 0);
  assign mul_go = go && (state == ST_MUL);
  assign div_go = go && (state == ST_DIV) && s_pos;

  always_comb begin
    pred_tmp = sat_w(XW'(dp) - XW'(c01) - XW'(c10) + XW'($signed({1'b0, angle_noise})));
    case (op)
      OP_ANGLE_PRED: begin opa = OW'({1'b0, dt}); opb = OW'(rate); end
      OP_DP:         begin opa = OW'({1'b0, dt}); opb = OW'(c11); end
      OP_C00_PRED:   begin opa = OW'({1'b0, dt}); opb = OW'(pred_tmp); end
      OP_C11_PRED:   begin opa = OW'({1'b0, bias_noise}); opb = OW'({1'b0, dt}); end
      OP_ANGLE_CORR: begin opa = OW'(k0); opb = OW'(y); end
      OP_BIAS_CORR:  begin opa = OW'(k1); opb = OW'(y); end
      OP_C10_CORR:   begin opa = OW'(k1); opb = OW'(c00); end
      OP_C00_CORR:   begin opa = OW'(k0); opb = OW'(c00); end
      OP_C11_CORR:   begin opa = OW'(k1); opb = OW'(c01); end
      OP_C01_CORR:   begin opa = OW'(k0); opb = OW'(c01); end
      default:       begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    case (paddr[3:2])
      REG_ANGLE_NOISE: prdata = {1'b0, angle_noise};
      REG_BIAS_NOISE:  prdata = {1'b0, bias_noise};
      REG_MEAS_NOISE:  prdata = {1'b0, meas_noise};
      default:         prdata = '0;
    endcase
  end

  kabf_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (opa),
    .b    (opb),
    .done (mul_done),
    .res  (mul_res)
  );

  kabf_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (divsel ? c10 : c00),
    .den  ((MAG+1)'(s_sum)),
    .done (div_done),
    .res  (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_ANGLE_PRED;
      go          <= 1'b0;
      divsel      <= 1'b0;
      m_tvalid    <= 1'b0;
      angle       <= '0;
      bias        <= '0;
      rate        <= '0;
      c00         <= '0;
      c01         <= '0;
      c10         <= '0;
      c11         <= '0;
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise  <= BIAS_NOISE_RST;
      meas_noise  <= MEAS_NOISE_RST;
    end else begin
      go <= 1'b0;
      // In the output state a taken result is replaced below, so the clear waits.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ANGLE_NOISE: angle_noise <= pwdata[30:0];
          REG_BIAS_NOISE:  bias_noise  <= pwdata[30:0];
          REG_MEAS_NOISE:  meas_noise  <= pwdata[30:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            m_angle <= s_tdata[31:0];
            dt      <= s_tdata[87:64];
            rate    <= sat_w(XW'(in_rate) - XW'(bias));
            op      <= OP_ANGLE_PRED;
            go      <= 1'b1;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (op)
              OP_ANGLE_PRED: angle <= sat_w(XW'(angle) + XW'(mul_res));
              OP_DP:         dp    <= mul_res;
              OP_C00_PRED: begin
                c00 <= sat_w(XW'(c00) + XW'(mul_res));
                c01 <= sat_w(XW'(c01) - XW'(dp));
                c10 <= sat_w(XW'(c10) - XW'(dp));
              end
              OP_C11_PRED: begin
                c11 <= sat_w(XW'(c11) + XW'(mul_res));
                y   <= sat_w(XW'(m_angle) - XW'(angle));
              end
              OP_ANGLE_CORR: angle <= sat_w(XW'(angle) + XW'(mul_res));
              OP_BIAS_CORR:  bias  <= sat_w(XW'(bias) + XW'(mul_res));
              OP_C10_CORR:   c10   <= sat_w(XW'(c10) - XW'(mul_res));
              OP_C00_CORR:   c00   <= sat_w(XW'(c00) - XW'(mul_res));
              OP_C11_CORR:   c11   <= sat_w(XW'(c11) - XW'(mul_res));
              OP_C01_CORR:   c01   <= sat_w(XW'(c01) - XW'(mul_res));
              default: ;
            endcase
            if (op == OP_C11_PRED) begin
              state  <= ST_DIV;
              divsel <= 1'b0;
              go     <= 1'b1;
            end else if (op == OP_C01_CORR) begin
              state <= ST_OUT;
            end else begin
              op <= op_after(op);
              go <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          // A non-positive innovation variance leaves both gains at zero.
          if (go && !s_pos) begin
            k0    <= '0;
            k1    <= '0;
            op    <= OP_ANGLE_CORR;
            state <= ST_MUL;
            go    <= 1'b1;
          end else if (div_done) begin
            if (!divsel) begin
              k0     <= div_res;
              divsel <= 1'b1;
              go     <= 1'b1;
            end else begin
              k1    <= div_res;
              op    <= OP_ANGLE_CORR;
              state <= ST_MUL;
              go    <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {sat_o(rate), sat_o(bias), sat_o(angle)};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL) else $error("multiplier finished outside the multiply phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV && s_pos)) else $error("divider finished outside a gain step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_MUL && op == OP_ANGLE_PRED && go))
    else $error("accepted transaction did not start the prediction");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished result was not presented");
`endif

endmodule
